// ===== src/fera_pkg.sv =====
`default_nettype none
package fera_pkg;

  localparam int MAX_REQ_DEFAULT = 16;
  localparam int CMD_W = 2;
  localparam int REQ_W = 4;
  localparam int TIME_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 5;
  localparam int POLICY_W = 2;
  localparam int COUNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WITHDRAW = 2'd2;

  localparam logic [POLICY_W-1:0] POLICY_FIFO = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_EDF = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;

  localparam logic [POLICY_W-1:0] POLICY_RESET = POLICY_FIFO;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  localparam logic [1:0] UPD_NONE = 2'd0;
  localparam logic [1:0] UPD_ENQ = 2'd1;
  localparam logic [1:0] UPD_START = 2'd2;
  localparam logic [1:0] UPD_DROP = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [REQ_W-1:0] requester;
    logic [TIME_W-1:0] now_ms;
    logic resource_free;
    logic [TIME_W-1:0] cooldown_end_ms;
    logic [TIME_W-1:0] start_time_ms;
  } item_t;

  typedef struct packed {
    logic granted;
    logic enqueued;
  } result_t;

  typedef struct packed {
    logic waiting;
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] last_start;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic [1:0] op;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] start_ms;
  } upd_t;

  typedef struct packed {
    logic fifo_ok;
    logic edf_ok;
  } verdict_t;

endpackage
`default_nettype wire

// ===== src/fera_cell.sv =====
`default_nettype none
module fera_cell (
  input  logic clk,
  input  logic rst,
  input  logic shift,
  input  fera_pkg::entry_t din,
  input  fera_pkg::upd_t upd,
  output fera_pkg::entry_t dout
);
  import fera_pkg::*;

  entry_t ent;
  entry_t ent_next;

  // apply the pending command to the entry passing through this cell
  always_comb begin
    ent_next = din;
    if (upd.hit) begin
      case (upd.op)
        UPD_ENQ: begin
          if (!din.waiting) begin
            ent_next.waiting = 1'b1;
            ent_next.stamp = upd.now_ms;
          end
        end
        UPD_START: ent_next.last_start = upd.start_ms;
        UPD_DROP: begin
          ent_next.waiting = 1'b0;
          ent_next.stamp = '0;
        end
        default: ent_next = din;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= '0;
    end else if (shift) begin
      ent <= ent_next;
    end
  end

  assign dout = ent;

endmodule
`default_nettype wire

// ===== src/fera_scan.sv =====
`default_nettype none
module fera_scan (
  input  logic clk,
  input  logic rst,
  input  logic clear,
  input  logic step,
  input  fera_pkg::entry_t head,
  input  logic is_target,
  input  logic counted,
  output fera_pkg::verdict_t verdict
);
  import fera_pkg::*;

  logic oth_any;
  logic [TIME_W-1:0] oth_min;
  logic w_any;
  logic [TIME_W-1:0] w_min_last;
  logic t_waiting;
  logic [TIME_W-1:0] t_stamp;
  logic [TIME_W-1:0] t_last;

  logic take_oth;
  logic take_w;

  assign take_oth = step && counted && !is_target && head.waiting &&
                    (!oth_any || (head.stamp < oth_min));
  assign take_w = step && counted && head.waiting &&
                  (!w_any || (head.last_start < w_min_last));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      oth_any <= 1'b0;
      w_any <= 1'b0;
    end else begin
      if (take_oth) begin
        oth_any <= 1'b1;
      end
      if (take_w) begin
        w_any <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_oth) begin
      oth_min <= head.stamp;
    end
    if (take_w) begin
      w_min_last <= head.last_start;
    end
    if (step && is_target) begin
      t_waiting <= head.waiting;
      t_stamp <= head.stamp;
      t_last <= head.last_start;
    end
  end

  // any other waiter blocks a requester that is not queued itself
  assign verdict.fifo_ok = !oth_any || (t_waiting && !(oth_min < t_stamp));
  assign verdict.edf_ok = !w_any || !(w_min_last < t_last);

endmodule
`default_nettype wire

// ===== src/fifo_edf_resource_arbiter_unit.sv =====
`default_nettype none
// Shared-resource arbiter. Per-requester queue flag, queue stamp and last
// start time live in a ring of MAX_REQUESTERS cells that rotates one place a
// cycle while a command is scanned; every command takes one full turn of the
// ring plus a settle state for the decision, and the result beat appears on
// done/result in the cycle after that state, so an item is taken only once
// the previous one is through (busy is high meanwhile). The result beat is
// shown for exactly one cycle and must be taken then. A new start is taken
// during the result beat. Configuration writes are always ready and belong
// in idle periods.
module fifo_edf_resource_arbiter_unit #(
  parameter int MAX_REQUESTERS = fera_pkg::MAX_REQ_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  fera_pkg::item_t item,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [fera_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fera_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic done,
  output fera_pkg::result_t result
);
  import fera_pkg::*;

  localparam int IDX_W = $clog2(MAX_REQUESTERS);
  localparam int CW = (IDX_W + 1 > REQ_W + 1) ? IDX_W + 1 : REQ_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_REQUESTERS - 1);
  localparam logic [CW-1:0] MAX_CW = CW'(MAX_REQUESTERS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN = 2'd2;

  logic [1:0] state;
  logic [IDX_W-1:0] cnt;
  item_t itm;
  logic [POLICY_W-1:0] policy_mode;
  logic [COUNT_W-1:0] requester_count;
  logic enq_seen;

  entry_t ring [MAX_REQUESTERS];
  upd_t upd;
  verdict_t verdict;

  logic accept;
  logic scanning;
  logic [CW-1:0] cnt_cw;
  logic [CW-1:0] who_cw;
  logic [CW-1:0] rc_cw;
  logic [CW-1:0] n_cw;
  logic counted;
  logic in_range;
  logic is_target;
  logic clear_ok;
  logic grant_next;

  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;
  assign scanning = (state == ST_SCAN);
  assign cfg_ready = 1'b1;

  assign cnt_cw = CW'(cnt);
  assign who_cw = CW'(itm.requester);
  assign rc_cw = CW'(requester_count);
  assign n_cw = (rc_cw > MAX_CW) ? MAX_CW : rc_cw;
  assign counted = (cnt_cw < n_cw);
  assign in_range = (who_cw < MAX_CW);
  assign is_target = in_range && (cnt_cw == who_cw);
  assign clear_ok = itm.resource_free && (itm.now_ms >= itm.cooldown_end_ms);

  always_comb begin
    upd.hit = scanning && is_target;
    upd.now_ms = itm.now_ms;
    upd.start_ms = itm.start_time_ms;
    case (itm.command)
      CMD_REQUEST: upd.op = clear_ok ? UPD_NONE : UPD_ENQ;
      CMD_SET_START: upd.op = UPD_START;
      CMD_WITHDRAW: upd.op = UPD_DROP;
      default: upd.op = UPD_NONE;
    endcase
  end

  // cell k takes from k+1; the head wraps to the tail, where updates land
  for (genvar k = 0; k < MAX_REQUESTERS; k++) begin : g_cell
    localparam int NXT = (k + 1) % MAX_REQUESTERS;
    upd_t cell_upd;
    assign cell_upd = (k == MAX_REQUESTERS - 1) ? upd : '0;
    fera_cell u_cell (
      .clk(clk),
      .rst(rst),
      .shift(scanning),
      .din(ring[NXT]),
      .upd(cell_upd),
      .dout(ring[k])
    );
  end

  fera_scan u_scan (
    .clk(clk),
    .rst(rst),
    .clear(accept),
    .step(scanning),
    .head(ring[0]),
    .is_target(is_target),
    .counted(counted),
    .verdict(verdict)
  );

  assign grant_next = in_range && (itm.command == CMD_REQUEST) && clear_ok &&
                      (((policy_mode == POLICY_FIFO) && verdict.fifo_ok) ||
                       ((policy_mode == POLICY_EDF) && verdict.edf_ok));

  always_ff @(posedge clk) begin
    if (accept) begin
      itm <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      enq_seen <= 1'b0;
      done <= 1'b0;
      result <= '0;
      policy_mode <= POLICY_RESET;
      requester_count <= COUNT_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POLICY: policy_mode <= cfg_data[POLICY_W-1:0];
          CFG_COUNT: requester_count <= cfg_data[COUNT_W-1:0];
          default: policy_mode <= policy_mode;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SCAN;
            cnt <= '0;
            enq_seen <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (upd.hit && (upd.op == UPD_ENQ) && !ring[0].waiting) begin
            enq_seen <= 1'b1;
          end
          if (cnt == LAST_IDX) begin
            state <= ST_FIN;
            cnt <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_FIN: begin
          state <= ST_IDLE;
          done <= 1'b1;
          result.granted <= grant_next;
          result.enqueued <= enq_seen;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FIN))
    else $error("result beat without a finished scan");

  a_start_scans: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_SCAN) && (cnt == '0))
    else $error("accepted item did not start a ring turn");

  a_turn_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && cnt == LAST_IDX) |=> (state == ST_FIN))
    else $error("ring turn did not end after the last cell");

  a_grant_xor_enq: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.granted && result.enqueued))
    else $error("request both granted and enqueued");

endmodule
`default_nettype wire

// ===== tb/tb_fifo_edf_resource_arbiter_unit.sv =====
`default_nettype none
module tb_fifo_edf_resource_arbiter_unit;
  import fera_pkg::*;

  localparam int MAX_REQ = MAX_REQ_DEFAULT;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam logic [POLICY_W-1:0] POLICY_DENY = 2'd2;
  localparam logic [POLICY_W-1:0] POLICY_DENY_ALT = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;
  localparam logic [TIME_W-1:0] T_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t item = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic done;
  result_t result;

  fifo_edf_resource_arbiter_unit #(.MAX_REQUESTERS(MAX_REQ)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .result(result)
  );

  always #10 clk = ~clk;

  // arbiter state as the testbench tracks it
  logic [POLICY_W-1:0] mode_q;
  logic [COUNT_W-1:0] count_q;
  logic waiting_q [MAX_REQ];
  logic [TIME_W-1:0] stamp_q [MAX_REQ];
  logic [TIME_W-1:0] last_start_q [MAX_REQ];

  result_t pending_verdicts [$];
  int errors = 0;
  int items_sent = 0;
  int verdicts_seen = 0;
  int grants_seen = 0;
  int enqueues_seen = 0;
  int reg_writes = 0;
  bit burst = 1'b0;

  function automatic int counted_span();
    return (int'(count_q) > MAX_REQ) ? MAX_REQ : int'(count_q);
  endfunction

  function automatic logic fifo_first(int who);
    int i;
    logic ok;
    ok = 1'b1;
    for (i = 0; i < counted_span(); i++)
      if (i != who && waiting_q[i] && (!waiting_q[who] || stamp_q[i] < stamp_q[who]))
        ok = 1'b0;
    return ok;
  endfunction

  function automatic logic edf_first(int who);
    int i;
    logic ok;
    ok = 1'b1;
    for (i = 0; i < counted_span(); i++)
      if (waiting_q[i] && last_start_q[i] < last_start_q[who])
        ok = 1'b0;
    return ok;
  endfunction

  // Apply one command to the tracked state and return its verdict.
  function automatic result_t arbitrate(item_t it);
    result_t r;
    int who;
    r = '0;
    who = int'(it.requester);
    case (it.command)
      CMD_REQUEST: begin
        if (it.resource_free && it.now_ms >= it.cooldown_end_ms) begin
          if (mode_q == POLICY_FIFO)
            r.granted = fifo_first(who);
          else if (mode_q == POLICY_EDF)
            r.granted = edf_first(who);
        end else if (!waiting_q[who]) begin
          waiting_q[who] = 1'b1;
          stamp_q[who] = it.now_ms;
          r.enqueued = 1'b1;
        end
      end
      CMD_SET_START: last_start_q[who] = it.start_time_ms;
      CMD_WITHDRAW: begin
        waiting_q[who] = 1'b0;
        stamp_q[who] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic item_t mk(logic [CMD_W-1:0] cmd, int who, logic [TIME_W-1:0] now,
                               logic free, logic [TIME_W-1:0] cool,
                               logic [TIME_W-1:0] st);
    item_t it;
    it.command = cmd;
    it.requester = who[REQ_W-1:0];
    it.now_ms = now;
    it.resource_free = free;
    it.cooldown_end_ms = cool;
    it.start_time_ms = st;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int roll;
    int span;
    roll = $urandom_range(0, 99);
    if (roll < 60)
      it.command = CMD_REQUEST;
    else if (roll < 75)
      it.command = CMD_SET_START;
    else if (roll < 95)
      it.command = CMD_WITHDRAW;
    else
      it.command = CMD_NOP;
    span = (counted_span() == 0) ? 1 : counted_span();
    // mostly requesters that take part in the comparisons
    if ($urandom_range(0, 3) != 0)
      it.requester = REQ_W'($urandom_range(0, span - 1));
    else
      it.requester = REQ_W'($urandom_range(0, MAX_REQ - 1));
    it.resource_free = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) begin
      it.now_ms = $urandom;
      it.cooldown_end_ms = $urandom;
      it.start_time_ms = $urandom;
    end else begin
      // narrow time window: stamps and start times collide and tie
      it.now_ms = $urandom_range(0, 40);
      it.cooldown_end_ms = $urandom_range(0, 40);
      it.start_time_ms = $urandom_range(0, 40);
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < 40)
      $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  task automatic send_item(input item_t it);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      // drop start, let the block go idle, then hold off for the gap
      start <= 1'b0;
      do @(posedge clk); while (busy !== 1'b0);
      repeat (gap - 1) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    pending_verdicts.push_back(arbitrate(it));
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_POLICY: mode_q = val[POLICY_W-1:0];
      CFG_COUNT: count_q = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Write both registers while idle; slip in a write to an unused index now and then.
  task automatic configure(input logic [POLICY_W-1:0] policy, input logic [COUNT_W-1:0] cnt);
    logic [CFG_DATA_W-1:0] pol_word;
    pol_word = {3'($urandom_range(0, 7)), policy};
    drain();
    write_reg(CFG_POLICY, pol_word);
    if ($urandom_range(0, 1))
      write_reg($urandom_range(0, 1) ? CFG_UNUSED_2 : CFG_UNUSED_3, 5'($urandom));
    write_reg(CFG_COUNT, cnt);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done !== 1'b0) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result beat %b with nothing outstanding", result));
      end else begin
        want = pending_verdicts.pop_front();
        if (result.granted !== want.granted)
          report_mismatch($sformatf("granted %b, want %b", result.granted, want.granted));
        if (result.enqueued !== want.enqueued)
          report_mismatch($sformatf("enqueued %b, want %b", result.enqueued, want.enqueued));
        verdicts_seen++;
        grants_seen += int'(want.granted);
        enqueues_seen += int'(want.enqueued);
      end
    end
  end

  task automatic test_fifo_directed();
    send_item(mk(CMD_REQUEST, 0, 10, 1'b1, 10, 0));
    send_item(mk(CMD_REQUEST, 3, 0, 1'b0, 0, 0));
    send_item(mk(CMD_REQUEST, 3, 5, 1'b0, 0, 0));
    send_item(mk(CMD_REQUEST, 5, 100, 1'b1, 200, 0));
    send_item(mk(CMD_REQUEST, 7, 300, 1'b1, 0, 0));
    send_item(mk(CMD_REQUEST, 5, 300, 1'b1, 0, 0));
    send_item(mk(CMD_REQUEST, 3, T_MAX, 1'b1, T_MAX, T_MAX));
    send_item(mk(CMD_NOP, 15, T_MAX, 1'b1, 0, T_MAX));
    send_item(mk(CMD_WITHDRAW, 7, 0, 1'b0, 0, 0));
    send_item(mk(CMD_WITHDRAW, 3, T_MAX, 1'b1, T_MAX, T_MAX));
    send_item(mk(CMD_REQUEST, 5, 0, 1'b1, 0, 0));
    send_item(mk(CMD_REQUEST, 15, 0, 1'b0, T_MAX, 0));
    send_item(mk(CMD_REQUEST, 5, 50, 1'b1, 0, 0));
  endtask

  task automatic test_edf_directed();
    configure(POLICY_EDF, 5'd16);
    send_item(mk(CMD_SET_START, 5, 0, 1'b0, 0, 10));
    send_item(mk(CMD_SET_START, 15, 0, 1'b0, 0, T_MAX));
    send_item(mk(CMD_REQUEST, 0, 1, 1'b1, 0, 0));
    send_item(mk(CMD_SET_START, 1, 0, 1'b0, 0, 20));
    send_item(mk(CMD_REQUEST, 1, 1, 1'b1, 0, 0));
    send_item(mk(CMD_REQUEST, 15, 1, 1'b1, 0, 0));
    send_item(mk(CMD_WITHDRAW, 5, 0, 1'b0, 0, 0));
    send_item(mk(CMD_REQUEST, 1, 1, 1'b1, 0, 0));
  endtask

  task automatic test_config_corners();
    configure(POLICY_DENY, 5'd16);
    send_item(mk(CMD_REQUEST, 0, 5, 1'b1, 0, 0));
    configure(POLICY_DENY_ALT, 5'd16);
    send_item(mk(CMD_REQUEST, 0, 5, 1'b1, 0, 0));
    // zero count: nothing to compare against, so a lone request wins
    configure(POLICY_FIFO, 5'd0);
    send_item(mk(CMD_REQUEST, 9, 5, 1'b1, 0, 0));
    configure(POLICY_FIFO, 5'd31);
    send_item(mk(CMD_REQUEST, 9, 5, 1'b1, 0, 0));
    configure(POLICY_EDF, 5'd1);
    send_item(mk(CMD_REQUEST, 15, 5, 1'b1, 0, 0));
    send_item(mk(CMD_WITHDRAW, 15, 0, 1'b0, 0, 0));
  endtask

  task automatic test_random();
    logic [POLICY_W-1:0] pols [9];
    logic [COUNT_W-1:0] cnts [9];
    int p;
    int k;
    pols = '{POLICY_FIFO, POLICY_EDF, POLICY_DENY, POLICY_FIFO, POLICY_EDF,
             POLICY_DENY_ALT, POLICY_FIFO, POLICY_EDF, POLICY_FIFO};
    cnts = '{5'd16, 5'd16, 5'd16, 5'd1, 5'd3, 5'd8, 5'd0, 5'd31, 5'd16};
    for (p = 0; p < 9; p++) begin
      if (p == 8) begin
        pols[p] = POLICY_W'($urandom_range(0, 3));
        cnts[p] = COUNT_W'($urandom_range(0, 31));
      end
      configure(pols[p], cnts[p]);
      burst = (p % 3 == 1);
      for (k = 0; k < 67; k++)
        send_item(random_item());
      burst = 1'b0;
    end
  endtask

  initial begin
    int i;
    mode_q = POLICY_RESET;
    count_q = COUNT_RESET;
    for (i = 0; i < MAX_REQ; i++) begin
      waiting_q[i] = 1'b0;
      stamp_q[i] = '0;
      last_start_q[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fifo_directed();
    test_edf_directed();
    test_config_corners();
    test_random();
    drain();
    repeat (MAX_REQ + 4) @(posedge clk);
    $display("arbiter run: %0d commands, %0d results checked, %0d grants, %0d enqueues",
             items_sent, verdicts_seen, grants_seen, enqueues_seen);
    $display("arbiter run: %0d register writes across FIFO, EDF and deny modes, counts 0 to 31",
             reg_writes);
    if (errors == 0 && pending_verdicts.size() == 0)
      $display("tb_fifo_edf_resource_arbiter_unit: clean");
    else
      $display("tb_fifo_edf_resource_arbiter_unit: errors");
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout waiting on the arbiter");
    $display("tb_fifo_edf_resource_arbiter_unit: errors");
    $finish;
  end

endmodule
`default_nettype wire
